// ----- rtl/ipv4_route_table_defines.svh -----
// Assertion macros for the IPv4 route table checker.
// Each macro expects signals named clock and reset in the scope that uses it.
`ifndef IPV4_ROUTE_TABLE_DEFINES_SVH
`define IPV4_ROUTE_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define IPV4RT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define IPV4RT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ipv4rt_pkg.sv -----
// Shared types and codes of the IPv4 route table.
// No dependencies; imported by the top level, the sequencer, the datapath and the checker.
`timescale 1ns / 1ps

package ipv4rt_pkg;

   localparam logic [1:0] OP_RESOLVE = 2'd0;
   localparam logic [1:0] OP_ADD     = 2'd1;
   localparam logic [1:0] OP_GET     = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_ROUTE   = 3'd1;
   localparam logic [2:0] ST_DUPLICATE  = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX  = 3'd4;

   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [7:0]  iface;
   } route_type;

   // Controller to datapath.
   typedef struct packed {
      logic start;   // capture the request, clear the walk
      logic issue;   // read the entry under the walk counter
      logic fetch;   // read the entry named by the request index
      logic finish;  // register the result, commit an add
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic can_issue;
      logic walk_done;
      logic slot_free;
   } ctrl_status_type;

endpackage

// ----- rtl/ipv4rt_channels.sv -----
// Request and response channel interfaces of the IPv4 route table.
// Plain valid/ready channels; no package dependency.
`timescale 1ns / 1ps

interface ipv4rt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] address;
   logic [31:0] netmask;
   logic [31:0] gateway;
   logic [7:0]  interface_id;
   logic [4:0]  entry_index;

   modport source (output valid, output opcode, output address, output netmask,
                   output gateway, output interface_id, output entry_index,
                   input ready);
   modport sink (input valid, input opcode, input address, input netmask,
                 input gateway, input interface_id, input entry_index,
                 output ready);
endinterface

interface ipv4rt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [4:0]  found_index;
   logic [31:0] route_dest;
   logic [31:0] route_mask;
   logic [31:0] route_gateway;
   logic [7:0]  route_interface;

   modport source (output valid, output status, output found_index, output route_dest,
                   output route_mask, output route_gateway, output route_interface,
                   input ready);
   modport sink (input valid, input status, input found_index, input route_dest,
                 input route_mask, input route_gateway, input route_interface,
                 output ready);
endinterface

// ----- rtl/ipv4_route_table.sv -----
// IPv4 route table, top level: joins the sequencer and the datapath to the
// request and response channels. Uses ipv4rt_pkg, ipv4rt_ctrl, ipv4rt_datapath.
//
// Usage: a request on req_bus carries an opcode (resolve, add, get, no-op) and
// its operands; each request yields exactly one response on rsp_bus with a
// status, the entry position and that entry's fields. Requests are served one
// at a time; req_bus.ready is high while the block is idle.
// Resolve and add walk the stored entries one per cycle through the single read
// port of the route memory, stopping early on an exact or duplicate match, so a
// walk covers at most TABLE_ENTRIES entries; get reads the one entry named by
// the request index when that index is in range, and no-op reads none.
// A new request is accepted the cycle after the result is registered, even
// while that response still waits on rsp_bus.ready; the next result is then
// held in the sequencer until the response register frees up.
// Reset (synchronous) empties the table and drops any pending response; no
// clearing pass is needed.
`timescale 1ns / 1ps

module ipv4_route_table #(
   parameter int TABLE_ENTRIES = 32
) (
   input logic          clock,
   input logic          reset,
   ipv4rt_req_if.sink   req_bus,
   ipv4rt_rsp_if.source rsp_bus
);
   import ipv4rt_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type stat;

   ipv4rt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_opcode (req_bus.opcode),
      .cmd        (cmd),
      .stat       (stat)
   );

   ipv4rt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_opcode          (req_bus.opcode),
      .req_address         (req_bus.address),
      .req_netmask         (req_bus.netmask),
      .req_gateway         (req_bus.gateway),
      .req_interface_id    (req_bus.interface_id),
      .req_entry_index     (req_bus.entry_index),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_status          (rsp_bus.status),
      .rsp_found_index     (rsp_bus.found_index),
      .rsp_route_dest      (rsp_bus.route_dest),
      .rsp_route_mask      (rsp_bus.route_mask),
      .rsp_route_gateway   (rsp_bus.route_gateway),
      .rsp_route_interface (rsp_bus.route_interface)
   );

endmodule

// ----- rtl/ipv4rt_ctrl.sv -----
// Sequencer of the IPv4 route table: accepts a request, runs the table walk,
// the single read or neither, then hands the result to the datapath. Uses ipv4rt_pkg.
`timescale 1ns / 1ps

module ipv4rt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   output ipv4rt_pkg::ctrl_cmd_type     cmd,
   input  ipv4rt_pkg::ctrl_status_type  stat
);
   import ipv4rt_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (req_opcode inside {OP_RESOLVE, OP_ADD}) begin
                  state_in = S_WALK;
               end else if (req_opcode == OP_GET) begin
                  state_in = S_FETCH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_WALK: begin
            cmd.issue = stat.can_issue;
            if (stat.walk_done) begin
               state_in = S_DONE;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the result
            if (stat.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/ipv4rt_datapath.sv -----
// Datapath of the IPv4 route table: request registers, route memory, match
// logic of the walk, entry count and the response register. Uses ipv4rt_pkg.
`timescale 1ns / 1ps

module ipv4rt_datapath #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ipv4rt_pkg::ctrl_cmd_type     cmd,
   output ipv4rt_pkg::ctrl_status_type  stat,
   input  logic [1:0]                   req_opcode,
   input  logic [31:0]                  req_address,
   input  logic [31:0]                  req_netmask,
   input  logic [31:0]                  req_gateway,
   input  logic [7:0]                   req_interface_id,
   input  logic [4:0]                   req_entry_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic [4:0]                   rsp_found_index,
   output logic [31:0]                  rsp_route_dest,
   output logic [31:0]                  rsp_route_mask,
   output logic [31:0]                  rsp_route_gateway,
   output logic [7:0]                   rsp_route_interface
);
   import ipv4rt_pkg::*;

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int XW = (CW > 5) ? CW : 5;
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   // request registers
   logic [1:0]  op_ff;
   logic [31:0] addr_ff;
   logic [31:0] mask_ff;
   logic [31:0] gw_ff;
   logic [7:0]  itf_ff;
   logic [4:0]  idx_ff;
   route_type   req_route;

   // table state
   route_type   route_mem_ff [TABLE_ENTRIES];
   logic [CW-1:0] count_ff, count_in;

   // walk state
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   route_type     rd_data_ff;
   logic          hit_ff, hit_in;
   logic          pick_ff, pick_in;
   logic          dflt_ff, dflt_in;
   route_type     pick_data_ff, pick_data_in;
   route_type     dflt_data_ff, dflt_data_in;
   logic [IW-1:0] pick_idx_ff, pick_idx_in;
   logic [IW-1:0] dflt_idx_ff, dflt_idx_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [4:0]    rsp_index_ff, rsp_index_in;
   route_type     rsp_route_ff, rsp_route_in;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic          more;
   logic          idx_ok;
   logic          table_full;
   logic          proc;
   logic          is_dflt;
   logic          exact;
   logic          masked;
   logic          same;

   assign req_route.dest    = addr_ff;
   assign req_route.mask    = mask_ff;
   assign req_route.gateway = gw_ff;
   assign req_route.iface   = itf_ff;

   assign more       = (cnt_ff < count_ff);
   assign idx_ok     = (XW'(idx_ff) < XW'(count_ff));
   assign table_full = (count_ff == FULL_COUNT);

   assign stat.can_issue = !hit_ff && more;
   assign stat.walk_done = hit_ff || (!more && !rd_valid_ff);
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;

   assign rd_en   = cmd.issue || (cmd.fetch && idx_ok);
   assign rd_addr = cmd.issue ? cnt_ff[IW-1:0] : IW'(idx_ff);
   assign wr_en   = cmd.finish && (op_ff == OP_ADD) && !hit_ff && !table_full;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem_ff[count_ff[IW-1:0]] <= req_route;
      end
      if (rd_en) begin
         rd_data_ff <= route_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= req_opcode;
         addr_ff <= req_address;
         mask_ff <= req_netmask;
         gw_ff   <= req_gateway;
         itf_ff  <= req_interface_id;
         idx_ff  <= req_entry_index;
      end
   end

   // compare the entry that came back from memory; stop on a hit
   assign proc    = rd_valid_ff && !hit_ff;
   assign is_dflt = (rd_data_ff.dest == 32'd0);
   assign exact   = (rd_data_ff.dest == addr_ff);
   assign masked  = !is_dflt &&
                    ((rd_data_ff.dest & rd_data_ff.mask) == (addr_ff & rd_data_ff.mask));
   assign same    = (rd_data_ff == req_route);

   always_comb begin
      cnt_in       = cnt_ff;
      rd_valid_in  = cmd.issue;
      rd_idx_in    = cmd.issue ? cnt_ff[IW-1:0] : rd_idx_ff;
      hit_in       = hit_ff;
      pick_in      = pick_ff;
      dflt_in      = dflt_ff;
      pick_data_in = pick_data_ff;
      pick_idx_in  = pick_idx_ff;
      dflt_data_in = dflt_data_ff;
      dflt_idx_in  = dflt_idx_ff;
      if (cmd.start) begin
         cnt_in      = '0;
         rd_valid_in = 1'b0;
         hit_in      = 1'b0;
         pick_in     = 1'b0;
         dflt_in     = 1'b0;
      end else begin
         if (cmd.issue) begin
            cnt_in = cnt_ff + CW'(1);
         end
         if (proc) begin
            if (op_ff == OP_ADD) begin
               if (same) begin
                  hit_in       = 1'b1;
                  pick_in      = 1'b1;
                  pick_data_in = rd_data_ff;
                  pick_idx_in  = rd_idx_ff;
               end
            end else begin
               if (is_dflt) begin
                  dflt_in      = 1'b1;
                  dflt_data_in = rd_data_ff;
                  dflt_idx_in  = rd_idx_ff;
               end
               if (exact || masked) begin
                  hit_in       = exact;
                  pick_in      = 1'b1;
                  pick_data_in = rd_data_ff;
                  pick_idx_in  = rd_idx_ff;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_status_in = ST_OK;
      rsp_index_in  = '0;
      rsp_route_in  = '0;
      case (op_ff)
         OP_RESOLVE: begin
            if (pick_ff) begin
               rsp_index_in = 5'(pick_idx_ff);
               rsp_route_in = pick_data_ff;
            end else if (dflt_ff) begin
               rsp_index_in = 5'(dflt_idx_ff);
               rsp_route_in = dflt_data_ff;
            end else begin
               rsp_status_in = ST_NO_ROUTE;
            end
         end
         OP_ADD: begin
            if (hit_ff) begin
               rsp_status_in = ST_DUPLICATE;
               rsp_index_in  = 5'(pick_idx_ff);
               rsp_route_in  = pick_data_ff;
            end else if (table_full) begin
               rsp_status_in = ST_TABLE_FULL;
            end else begin
               rsp_index_in = 5'(count_ff[IW-1:0]);
               rsp_route_in = req_route;
            end
         end
         OP_GET: begin
            if (idx_ok) begin
               rsp_index_in = idx_ff;
               rsp_route_in = rd_data_ff;
            end else begin
               rsp_status_in = ST_BAD_INDEX;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   assign count_in     = wr_en ? (count_ff + CW'(1)) : count_ff;
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         pick_ff      <= 1'b0;
         dflt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         pick_ff      <= pick_in;
         dflt_ff      <= dflt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      pick_data_ff <= pick_data_in;
      pick_idx_ff  <= pick_idx_in;
      dflt_data_ff <= dflt_data_in;
      dflt_idx_ff  <= dflt_idx_in;
      if (cmd.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_route_ff  <= rsp_route_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found_index     = rsp_index_ff;
   assign rsp_route_dest      = rsp_route_ff.dest;
   assign rsp_route_mask      = rsp_route_ff.mask;
   assign rsp_route_gateway   = rsp_route_ff.gateway;
   assign rsp_route_interface = rsp_route_ff.iface;

endmodule

// ----- rtl/ipv4rt_checker.sv -----
// Port-level checks of the IPv4 route table, bound to the top level.
// Uses ipv4rt_pkg and the macros of ipv4_route_table_defines.svh.
`timescale 1ns / 1ps
`include "ipv4_route_table_defines.svh"

module ipv4rt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [4:0]  rsp_found_index,
   input logic [31:0] rsp_route_dest,
   input logic [31:0] rsp_route_mask,
   input logic [31:0] rsp_route_gateway,
   input logic [7:0]  rsp_route_interface
);
   import ipv4rt_pkg::*;

   `IPV4RT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `IPV4RT_ASSERT_SAME(a_empty_result, rsp_valid && (rsp_status == ST_NO_ROUTE || rsp_status == ST_TABLE_FULL || rsp_status == ST_BAD_INDEX), rsp_found_index == 5'd0 && rsp_route_dest == 32'd0 && rsp_route_mask == 32'd0 && rsp_route_gateway == 32'd0 && rsp_route_interface == 8'd0, "failed request carries entry data")
   `IPV4RT_ASSERT_SAME(a_reset_clears, $past(reset), !rsp_valid, "response valid right after reset")
   `IPV4RT_ASSERT_SAME(a_min_latency, $rose(rsp_valid), !$past(req_valid && req_ready), "response one cycle after request")

endmodule

bind ipv4_route_table ipv4rt_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_status          (rsp_bus.status),
   .rsp_found_index     (rsp_bus.found_index),
   .rsp_route_dest      (rsp_bus.route_dest),
   .rsp_route_mask      (rsp_bus.route_mask),
   .rsp_route_gateway   (rsp_bus.route_gateway),
   .rsp_route_interface (rsp_bus.route_interface)
);
